/* hdl/sliding_window_percentile_defines.svh */
// Assertion macros shared by the sliding window percentile design.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef SLIDING_WINDOW_PERCENTILE_DEFINES_SVH
`define SLIDING_WINDOW_PERCENTILE_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/swp_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and command/status types of the sliding window percentile block.
// No dependencies; used by the interfaces, the controller and the datapath.
package swp_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = 7;
  localparam int SAMPLE_W   = 32;
  localparam int NUM_PCT    = 3;

  localparam int Y_W        = $clog2(99 * WINDOW_MAX + 100);
  localparam int RECIP      = 167773;
  localparam int RECIP_W    = 18;
  localparam int RECIP_SH   = 24;

  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(60);

  localparam logic [6:0] PCT_MED = 7'd50;
  localparam logic [6:0] PCT_P90 = 7'd90;
  localparam logic [6:0] PCT_P99 = 7'd99;

  typedef struct packed {
    logic take_sample;
    logic store_write;
    logic rank_mul;
    logic rank_fin;
    logic cand_read;
    logic cand_load;
    logic scan_step;
    logic eval;
    logic out_load;
  } swp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic cand_last;
    logic out_free;
  } swp_stat_t;

endpackage

/* hdl/swp_in_if.sv */
`timescale 1ns / 1ps
// Input channel of the sliding window percentile block: one sample per word.
// Depends on swp_pkg for the sample width.
interface swp_in_if import swp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;

  modport source(output valid, output sample_value, input ready);
  modport sink(input valid, input sample_value, output ready);
endinterface

/* hdl/swp_out_if.sv */
`timescale 1ns / 1ps
// Output channel of the sliding window percentile block: three percentiles and a count.
// Depends on swp_pkg for the field widths.
interface swp_out_if import swp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] median_value;
  logic [SAMPLE_W-1:0] p90_value;
  logic [SAMPLE_W-1:0] p99_value;
  logic [CNT_W-1:0]    fill_count;

  modport source(output valid, output median_value, output p90_value, output p99_value,
                 output fill_count, input ready);
  modport sink(input valid, input median_value, input p90_value, input p99_value,
               input fill_count, output ready);
endinterface

/* hdl/sliding_window_percentile.sv */
`timescale 1ns / 1ps
// A word is accepted only in the idle state, after the previous result is loaded for output.
// The counting passes read one sample a cycle through the single sample memory read port.
// A new sample is accepted while the previous result still waits on the output register.
// Reset clears control, counts and the output valid flag; the window length returns to 60.
// The sample memory is not cleared; only written entries are ever used in a result.
`include "sliding_window_percentile_defines.svh"

module sliding_window_percentile import swp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [CNT_W-1:0] cfg_wr_data_i,
  swp_in_if.sink           in_i,
  swp_out_if.source        out_o
);

  swp_cmd_t  cmd;
  swp_stat_t stat;

  swp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  swp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .sample_i      (in_i.sample_value),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .median_o      (out_o.median_value),
    .p90_o         (out_o.p90_value),
    .p99_o         (out_o.p99_value),
    .fill_o        (out_o.fill_count)
  );

  `ASSERT_NEXT(a_accept_starts_write, clk_i, rst_ni, in_i.valid && in_i.ready, cmd.store_write, "accepted word did not start a store write")
  `ASSERT_IMPLIES(a_load_needs_room, clk_i, rst_ni, cmd.out_load, stat.out_free, "result loaded over an untaken word")
  `ASSERT_IMPLIES(a_fill_in_range, clk_i, rst_ni, out_o.valid, (out_o.fill_count != '0) && (out_o.fill_count <= CNT_W'(WINDOW_MAX)), "fill count out of range")
  `ASSERT_NEXT(a_taken_drains, clk_i, rst_ni, out_o.valid && out_o.ready && !cmd.out_load, !out_o.valid, "taken word still shown as valid")

endmodule

/* hdl/swp_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences store update, rank setup, the counting passes and the output load.
// Depends on swp_pkg for the command and status types.
module swp_ctrl import swp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  swp_stat_t stat_i,
  output swp_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WRITE = 9'b000000010,
    S_RANK1 = 9'b000000100,
    S_RANK2 = 9'b000001000,
    S_CAND  = 9'b000010000,
    S_LOAD  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_EVAL  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_sample = 1'b1;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.store_write = 1'b1;
        state_d = S_RANK1;
      end
      S_RANK1: begin
        cmd_o.rank_mul = 1'b1;
        state_d = S_RANK2;
      end
      S_RANK2: begin
        cmd_o.rank_fin = 1'b1;
        state_d = S_CAND;
      end
      S_CAND: begin
        cmd_o.cand_read = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.cand_load = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = stat_i.cand_last ? S_DONE : S_CAND;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/swp_dp.sv */
`timescale 1ns / 1ps
// Datapath: sample memory, window pointers, rank arithmetic, counting pass and output word.
// Depends on swp_pkg; driven by swp_ctrl through command and status structs.
module swp_dp import swp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swp_cmd_t            cmd_i,
  output swp_stat_t           stat_o,
  input  logic                cfg_wr_en_i,
  input  logic [CNT_W-1:0]    cfg_wr_data_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [SAMPLE_W-1:0] median_o,
  output logic [SAMPLE_W-1:0] p90_o,
  output logic [SAMPLE_W-1:0] p99_o,
  output logic [CNT_W-1:0]    fill_o
);

  localparam logic [6:0] PCT [NUM_PCT] = '{PCT_MED, PCT_P90, PCT_P99};

  logic [SAMPLE_W-1:0] mem_q [WINDOW_MAX];
  logic [SAMPLE_W-1:0] rd_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;

  logic [CNT_W-1:0]    wlen_q;
  logic [CNT_W-1:0]    held_q, held_d;
  logic [ADDR_W-1:0]   oldest_q, oldest_d;
  logic [SAMPLE_W-1:0] sample_q;
  logic [CNT_W-1:0]    len_eff;
  logic [CNT_W-1:0]    held_sat;
  logic [ADDR_W-1:0]   old_wrap;
  logic [CNT_W-1:0]    old_next;

  logic [Y_W-1:0]      y_q [NUM_PCT];
  logic [ADDR_W-1:0]   rank_q [NUM_PCT];
  logic [ADDR_W-1:0]   rank_d [NUM_PCT];

  logic [ADDR_W-1:0]   i_q;
  logic [CNT_W-1:0]    k_q;
  logic [SAMPLE_W-1:0] cand_q;
  logic [CNT_W-1:0]    lt_q;
  logic [CNT_W-1:0]    le_q;
  logic [SAMPLE_W-1:0] res_q [NUM_PCT];
  logic                hit [NUM_PCT];

  logic                out_vld_q;

  always_comb begin
    if (wlen_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (wlen_q > CNT_W'(WINDOW_MAX)) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = wlen_q;
    end
    held_sat = (held_q > len_eff) ? len_eff : held_q;
    old_wrap = ({1'b0, oldest_q} >= len_eff) ? '0 : oldest_q;
    old_next = {1'b0, old_wrap} + CNT_W'(1);
    if (held_sat < len_eff) begin
      wr_addr  = held_sat[ADDR_W-1:0];
      held_d   = held_sat + CNT_W'(1);
      oldest_d = old_wrap;
    end else begin
      wr_addr  = old_wrap;
      held_d   = held_sat;
      oldest_d = (old_next == len_eff) ? '0 : old_next[ADDR_W-1:0];
    end
  end

  assign rd_addr = cmd_i.cand_read ? i_q : k_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_write) begin
      mem_q[wr_addr] <= sample_q;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    for (int p = 0; p < NUM_PCT; p++) begin
      logic [Y_W+RECIP_W-1:0] prod;
      logic [CNT_W-1:0]       up;
      logic [CNT_W-1:0]       idx;
      prod = Y_W'(y_q[p]) * RECIP_W'(RECIP);
      up   = prod[RECIP_SH +: CNT_W];
      idx  = (up == '0) ? '0 : up - CNT_W'(1);
      if (idx > held_q - CNT_W'(1)) begin
        idx = held_q - CNT_W'(1);
      end
      rank_d[p] = idx[ADDR_W-1:0];
      hit[p] = (lt_q <= {1'b0, rank_q[p]}) && (le_q > {1'b0, rank_q[p]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q    <= WINDOW_RESET;
      held_q    <= '0;
      oldest_q  <= '0;
      out_vld_q <= 1'b0;
      i_q       <= '0;
      k_q       <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        wlen_q <= cfg_wr_data_i;
      end
      if (cmd_i.store_write) begin
        held_q   <= held_d;
        oldest_q <= oldest_d;
      end
      if (cmd_i.rank_fin) begin
        i_q <= '0;
      end else if (cmd_i.eval) begin
        i_q <= i_q + ADDR_W'(1);
      end
      if (cmd_i.cand_load) begin
        k_q <= '0;
      end else if (cmd_i.scan_step) begin
        k_q <= k_q + CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_sample) begin
      sample_q <= sample_i;
    end
    for (int p = 0; p < NUM_PCT; p++) begin
      if (cmd_i.rank_mul) begin
        y_q[p] <= Y_W'(PCT[p]) * Y_W'(held_q) + Y_W'(99);
      end
      if (cmd_i.rank_fin) begin
        rank_q[p] <= rank_d[p];
      end
      if (cmd_i.eval && hit[p]) begin
        res_q[p] <= cand_q;
      end
    end
    if (cmd_i.cand_load) begin
      cand_q <= rd_q;
      lt_q   <= '0;
      le_q   <= '0;
    end else if (cmd_i.scan_step && (k_q != '0)) begin
      if (rd_q < cand_q) begin
        lt_q <= lt_q + CNT_W'(1);
      end
      if (rd_q <= cand_q) begin
        le_q <= le_q + CNT_W'(1);
      end
    end
    if (cmd_i.out_load) begin
      median_o <= res_q[0];
      p90_o    <= res_q[1];
      p99_o    <= res_q[2];
      fill_o   <= held_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign stat_o.scan_last = (k_q == held_q);
  assign stat_o.cand_last = ({1'b0, i_q} == held_q - CNT_W'(1));
  assign stat_o.out_free  = !out_vld_q || out_ready_i;

endmodule
